// ===== src/tsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the time-set command parser.
// Depends on nothing; the top level imports it.
package tsc_pkg;

	typedef logic [4:0] pos_t;

	// Character positions in "TIME=YYYY-MM-DD hh:mm:ss".
	localparam pos_t POS_PREFIX_END = 5'd5;
	localparam pos_t POS_DASH_A     = 5'd9;
	localparam pos_t POS_DASH_B     = 5'd12;
	localparam pos_t POS_SPACE      = 5'd15;
	localparam pos_t POS_COLON_A    = 5'd18;
	localparam pos_t POS_COLON_B    = 5'd21;
	localparam pos_t CMD_LEN        = 5'd24;
	localparam pos_t POS_SAT        = 5'd25;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [7:0] PREFIX_CHARS [5] = '{8'h54, 8'h49, 8'h4D, 8'h45, 8'h3D};

	localparam logic [13:0] YEAR_MIN = 14'd2000;
	localparam logic [13:0] YEAR_MAX = 14'd2099;

	localparam logic [4:0] MONTH_DAYS [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
	localparam logic [2:0] MONTH_SHIFT [12] = '{3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3,
		3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4};
	localparam logic [4:0] LEAP_FEB_DAYS = 5'd29;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_FORMAT = 2'd1,
		STATUS_RANGE  = 2'd2
	} status_t;

	// One byte of the command line.
	typedef struct packed {
		logic [7:0] char_byte;
		logic       line_end;
	} cmd_word_t;

	// One parse result.
	typedef struct packed {
		logic [1:0] status;
		logic [6:0] year_two_digit;
		logic [3:0] month_out;
		logic [4:0] day_out;
		logic [4:0] hour_out;
		logic [5:0] minute_out;
		logic [5:0] second_out;
		logic [2:0] weekday_out;
	} rsp_word_t;

endpackage

// ===== src/tsc_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream channel with a typed payload.
// Depends on nothing; the payload type is given where it is instantiated.
interface tsc_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== src/time_set_command_parser.sv =====
`timescale 1ns / 1ps
// Top level of the time-set command parser.
// Depends on tsc_pkg and tsc_stream_if.

// Parses "TIME=YYYY-MM-DD hh:mm:ss" on the cmd channel, one byte per cycle while
// cmd.ready is high, and gives one result word on the rsp channel for each byte
// that carries line_end. The per-byte character check and decimal accumulate is
// combinational, so a byte can be taken in every cycle in which cmd.ready is high.
// Accepting the line-ending byte captures the finished fields into the s2
// registers; the range check and the weekday are then registered into the
// result register once rsp is free. Up to two line results can be held
// while rsp is stalled; cmd is held off only when both are full. No
// initialization pass follows reset.
module time_set_command_parser (
	input  logic clk,
	input  logic arst_n,
	tsc_stream_if.sink   cmd,
	tsc_stream_if.source rsp
);
	import tsc_pkg::*;

	// Line state.
	pos_t        pos_q;
	logic        bad_q;
	logic        ended_q;
	logic [13:0] year_q;
	logic [6:0]  month_q, day_q, hour_q, minute_q, second_q;

	pos_t        pos_n;
	logic        bad_n;
	logic        ended_n;
	logic [13:0] year_n;
	logic [6:0]  month_n, day_n, hour_n, minute_n, second_n;

	// Captured line, waiting for the range check.
	logic        snap_v_s2;
	pos_t        pos_s2;
	logic        bad_s2;
	logic [13:0] year_s2;
	logic [6:0]  month_s2, day_s2, hour_s2, minute_s2, second_s2;

	// Result register.
	logic        res_v_s3;
	rsp_word_t   res_s3;
	rsp_word_t   res_n;

	logic        rsp_free;
	logic        cmd_take;
	logic [7:0]  c;
	logic        is_digit;
	logic [3:0]  dv;

	function automatic logic [13:0] acc14(input logic [13:0] a, input logic [3:0] d);
		return (a << 3) + (a << 1) + {10'd0, d};
	endfunction

	function automatic logic [6:0] acc7(input logic [6:0] a, input logic [3:0] d);
		return (a << 3) + (a << 1) + {3'd0, d};
	endfunction

	// Handshakes.
	assign rsp_free  = !res_v_s3 || rsp.ready;
	assign cmd.ready = !snap_v_s2 || rsp_free;
	assign cmd_take  = cmd.valid && cmd.ready;
	assign rsp.valid = res_v_s3;
	assign rsp.payload = res_s3;

	assign c        = cmd.payload.char_byte;
	assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	assign dv       = c[3:0];

	// Character check and digit accumulate for the incoming byte.
	always_comb begin
		pos_n    = pos_q;
		bad_n    = bad_q;
		ended_n  = ended_q;
		year_n   = year_q;
		month_n  = month_q;
		day_n    = day_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		if (!ended_q) begin
			if (c == CHAR_NUL) begin
				ended_n = 1'b1;
			end else begin
				priority if (pos_q < POS_PREFIX_END) begin
					if (c != PREFIX_CHARS[pos_q[2:0]]) bad_n = 1'b1;
				end else if (pos_q == POS_DASH_A || pos_q == POS_DASH_B) begin
					if (c != CHAR_DASH) bad_n = 1'b1;
				end else if (pos_q == POS_SPACE) begin
					if (c != CHAR_SPACE) bad_n = 1'b1;
				end else if (pos_q == POS_COLON_A || pos_q == POS_COLON_B) begin
					if (c != CHAR_COLON) bad_n = 1'b1;
				end else if (pos_q < CMD_LEN) begin
					priority if (!is_digit) begin
						bad_n = 1'b1;
					end else if (pos_q < POS_DASH_A) begin
						year_n = acc14(year_q, dv);
					end else if (pos_q < POS_DASH_B) begin
						month_n = acc7(month_q, dv);
					end else if (pos_q < POS_SPACE) begin
						day_n = acc7(day_q, dv);
					end else if (pos_q < POS_COLON_A) begin
						hour_n = acc7(hour_q, dv);
					end else if (pos_q < POS_COLON_B) begin
						minute_n = acc7(minute_q, dv);
					end else begin
						second_n = acc7(second_q, dv);
					end
				end else begin
					bad_n = 1'b1;
				end
				if (pos_q < POS_SAT) pos_n = pos_q + 5'd1;
			end
		end
	end

	// Line state registers; a line-ending byte returns them to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			bad_q    <= 1'b0;
			ended_q  <= 1'b0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
		end else if (cmd_take) begin
			if (cmd.payload.line_end) begin
				pos_q    <= '0;
				bad_q    <= 1'b0;
				ended_q  <= 1'b0;
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
			end else begin
				pos_q    <= pos_n;
				bad_q    <= bad_n;
				ended_q  <= ended_n;
				year_q   <= year_n;
				month_q  <= month_n;
				day_q    <= day_n;
				hour_q   <= hour_n;
				minute_q <= minute_n;
				second_q <= second_n;
			end
		end
	end

	// Capture the finished line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_v_s2 <= 1'b0;
		end else if (cmd_take && cmd.payload.line_end) begin
			snap_v_s2 <= 1'b1;
		end else if (rsp_free) begin
			snap_v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take && cmd.payload.line_end) begin
			pos_s2    <= pos_n;
			bad_s2    <= bad_n;
			year_s2   <= year_n;
			month_s2  <= month_n;
			day_s2    <= day_n;
			hour_s2   <= hour_n;
			minute_s2 <= minute_n;
			second_s2 <= second_n;
		end
	end

	// Range checks and weekday of the captured line.
	logic       fmt_fail;
	logic       year_ok, month_ok, day_ok, time_ok;
	logic [6:0] yy;
	logic [6:0] wk_year;
	logic [3:0] mon_idx;
	logic [4:0] dlim;
	logic [6:0] yk;
	logic [7:0] wsum;
	logic [12:0] wprod;
	logic [4:0] wq;
	logic [7:0] wrem;
	logic [2:0] wday;

	always_comb begin
		fmt_fail = bad_s2 || (pos_s2 != CMD_LEN);
		year_ok  = (year_s2 >= YEAR_MIN) && (year_s2 <= YEAR_MAX);
		month_ok = (month_s2 >= 7'd1) && (month_s2 <= 7'd12);
		time_ok  = (hour_s2 <= 7'd23) && (minute_s2 <= 7'd59) && (second_s2 <= 7'd59);
		yy       = 7'(year_s2 - YEAR_MIN);
		mon_idx  = month_ok ? (month_s2[3:0] - 4'd1) : 4'd0;

		// Inside 2000..2099 the leap rule reduces to a multiple of four.
		if (month_s2 == 7'd2 && yy[1:0] == 2'd0) dlim = LEAP_FEB_DAYS;
		else dlim = MONTH_DAYS[mon_idx];
		day_ok = (day_s2 >= 7'd1) && (day_s2 <= {2'd0, dlim});

		// Sakamoto's sum reduced mod 7 for years 1999..2099: the century terms
		// of 2000 + k cancel, and 1999 leaves a residue of five.
		if (month_s2 < 7'd3) begin
			if (yy == 7'd0) begin
				yk      = 7'd0;
				wk_year = 7'd5;
			end else begin
				yk      = yy - 7'd1;
				wk_year = yk + (yk >> 2);
			end
		end else begin
			yk      = yy;
			wk_year = yk + (yk >> 2);
		end
		wsum  = {1'b0, wk_year} + {5'd0, MONTH_SHIFT[mon_idx]} + {1'b0, day_s2};
		// Quotient by 7 through a reciprocal that never overshoots.
		wprod = {5'd0, wsum} * 13'd36;
		wq    = wprod[12:8];
		wrem  = wsum - {3'd0, wq} * 8'd7;
		if (wrem >= 8'd7) wrem = wrem - 8'd7;
		wday  = (wrem[2:0] == 3'd0) ? 3'd7 : wrem[2:0];

		res_n = '0;
		priority if (fmt_fail) begin
			res_n.status = STATUS_FORMAT;
		end else if (!(year_ok && month_ok && time_ok && day_ok)) begin
			res_n.status = STATUS_RANGE;
		end else begin
			res_n.status         = STATUS_OK;
			res_n.year_two_digit = yy;
			res_n.month_out      = month_s2[3:0];
			res_n.day_out        = day_s2[4:0];
			res_n.hour_out       = hour_s2[4:0];
			res_n.minute_out     = minute_s2[5:0];
			res_n.second_out     = second_s2[5:0];
			res_n.weekday_out    = wday;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s3 <= 1'b0;
		end else if (rsp_free) begin
			res_v_s3 <= snap_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_free && snap_v_s2) begin
			res_s3 <= res_n;
		end
	end

endmodule
